### rtl/core/iplc_pkg.sv
// Shared types and constants of the IPv4 source LRU packet counter.
package iplc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef enum logic {
        OP_FRAME_BYTE = 1'b0,
        OP_READ_ENTRY = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_REPORT  = 1'b0,
        KIND_READOUT = 1'b1
    } t_result_kind;

    typedef enum logic {
        CMD_FRAME_END = 1'b0,
        CMD_READ      = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  data_byte;
        logic        end_of_frame;
        logic [3:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        t_result_kind result_kind;
        logic         counted;
        logic [31:0]  source_address;
        logic [31:0]  packet_count;
        logic         evicted;
        logic         entry_valid;
    } t_out_item;

    // Request handed from the parser to the table engine
    typedef struct packed {
        t_cmd_kind   kind;
        logic        counted;
        logic [31:0] source_address;
        logic [3:0]  entry_index;
    } t_cmd;

endpackage

### rtl/core/iplc_stream_if.sv
// Valid/ready stream interface carrying one request payload.
interface iplc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/iplc_parser.sv
// Front end: byte-wise frame header parser that issues table requests.
module iplc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  iplc_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_full,
    output logic              o_push,
    output iplc_pkg::t_cmd    o_cmd
);
    localparam logic [5:0] ETYPE_FIRST   = 6'd12;
    localparam logic [5:0] ETYPE_LAST    = 6'd13;
    localparam logic [5:0] SRC_FIRST     = 6'd26;
    localparam logic [5:0] SRC_LAST      = 6'd29;
    localparam logic [5:0] MIN_LAST_POS  = 6'd33;  // last byte of a 34-byte frame
    localparam logic [5:0] POS_MAX       = 6'd63;

    logic [5:0]  r_byte_pos;
    logic [15:0] r_ether_type;
    logic [31:0] r_source;
    logic [5:0]  n_byte_pos;
    logic [15:0] n_ether_type;
    logic [31:0] n_source;
    logic        accept;
    logic        is_byte;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign is_byte = (i_item.opcode == iplc_pkg::OP_FRAME_BYTE);

    always_comb begin
        n_ether_type = r_ether_type;
        n_source     = r_source;
        if (r_byte_pos == ETYPE_FIRST || r_byte_pos == ETYPE_LAST) begin
            n_ether_type = {r_ether_type[7:0], i_item.data_byte};
        end
        if (r_byte_pos >= SRC_FIRST && r_byte_pos <= SRC_LAST) begin
            n_source = {r_source[23:0], i_item.data_byte};
        end
        n_byte_pos = (r_byte_pos < POS_MAX) ? r_byte_pos + 6'd1 : r_byte_pos;
    end

    always_comb begin
        o_push               = accept && (!is_byte || i_item.end_of_frame);
        o_cmd.kind           = is_byte ? iplc_pkg::CMD_FRAME_END : iplc_pkg::CMD_READ;
        o_cmd.counted        = (r_byte_pos >= MIN_LAST_POS)
                               && (n_ether_type == iplc_pkg::ETHERTYPE_IPV4);
        o_cmd.source_address = n_source;
        o_cmd.entry_index    = i_item.entry_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_ether_type <= '0;
            r_source     <= '0;
        end else if (accept && is_byte) begin
            if (i_item.end_of_frame) begin
                r_byte_pos   <= '0;
                r_ether_type <= '0;
                r_source     <= '0;
            end else begin
                r_byte_pos   <= n_byte_pos;
                r_ether_type <= n_ether_type;
                r_source     <= n_source;
            end
        end
    end

endmodule

### rtl/core/iplc_cmd_queue.sv
// Short request queue between the parser and the table engine.
module iplc_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  iplc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output iplc_pkg::t_cmd o_head
);
    localparam int PTR_W = $clog2(iplc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(iplc_pkg::QUEUE_DEPTH + 1);

    iplc_pkg::t_cmd   r_mem [iplc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(iplc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/iplc_table.sv
// Back end: fully associative LRU flow table with registered result stage.
module iplc_table #(
    parameter int TABLE_ENTRIES = iplc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_WIDTH   = iplc_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  iplc_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output iplc_pkg::t_out_item o_out_item,
    input  logic               i_out_ready
);
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int N      = TABLE_ENTRIES;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    t_state                   r_state;
    logic                     r_out_valid;
    iplc_pkg::t_out_item      r_out;
    logic                     n_out_valid;

    logic [31:0]              r_key;
    logic [N-1:0]             r_hit_vec;
    logic [N-1:0]             r_free_vec;
    logic [N-1:0]             r_victim_vec;

    logic [N-1:0]             r_slot_valid;
    logic [31:0]              r_slot_addr  [N];
    logic [COUNT_WIDTH-1:0]   r_slot_count [N];
    logic [SLOT_W-1:0]        r_rank       [N];

    logic                     out_can;
    logic                     is_read;
    logic                     is_lookup;
    logic                     rd_in_range;
    logic [SLOT_W-1:0]        rd_slot;
    logic [N-1:0]             hit_vec;
    logic [N-1:0]             free_vec;
    logic [N-1:0]             victim_vec;
    logic                     hit_any;
    logic                     free_any;
    logic [N-1:0]             pick_vec;
    logic [SLOT_W-1:0]        upd_slot;
    logic [SLOT_W-1:0]        sel_slot;
    logic [31:0]              sel_addr;
    logic [COUNT_WIDTH-1:0]   sel_count;
    logic                     sel_valid;
    logic [SLOT_W-1:0]        old_rank;
    logic [COUNT_WIDTH-1:0]   new_count;
    logic                     upd_fire;
    iplc_pkg::t_out_item      rd_out;

    assign out_can     = !r_out_valid || i_out_ready;
    assign is_read     = (i_cmd.kind == iplc_pkg::CMD_READ);
    assign is_lookup   = !is_read && i_cmd.counted;
    assign rd_in_range = (32'(i_cmd.entry_index) < 32'(N));
    assign rd_slot     = SLOT_W'(i_cmd.entry_index);

    // Parallel match against every slot
    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit_vec[i]    = r_slot_valid[i] && (r_slot_addr[i] == i_cmd.source_address);
            free_vec[i]   = !r_slot_valid[i];
            victim_vec[i] = r_slot_valid[i] && (r_rank[i] == SLOT_W'(N - 1));
        end
    end

    assign hit_any  = |r_hit_vec;
    assign free_any = |r_free_vec;
    assign pick_vec = hit_any ? r_hit_vec : (free_any ? r_free_vec : r_victim_vec);

    // Lowest index wins
    always_comb begin
        upd_slot = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (pick_vec[i]) begin
                upd_slot = SLOT_W'(i);
            end
        end
    end

    assign sel_slot  = (r_state == ST_UPDATE) ? upd_slot : rd_slot;
    assign sel_addr  = r_slot_addr[sel_slot];
    assign sel_count = r_slot_count[sel_slot];
    assign sel_valid = r_slot_valid[sel_slot];
    assign old_rank  = r_rank[upd_slot];
    assign new_count = hit_any ? sel_count + COUNT_WIDTH'(1) : COUNT_WIDTH'(1);
    assign upd_fire  = (r_state == ST_UPDATE) && out_can;

    // Readout, or report of an uncounted frame (all zero)
    always_comb begin
        rd_out             = '0;
        rd_out.result_kind = is_read ? iplc_pkg::KIND_READOUT : iplc_pkg::KIND_REPORT;
        if (is_read && rd_in_range && sel_valid) begin
            rd_out.entry_valid    = 1'b1;
            rd_out.source_address = sel_addr;
            rd_out.packet_count   = 32'(sel_count);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if ((r_state == ST_IDLE) && i_cmd_valid && !is_lookup && out_can) begin
            n_out_valid = 1'b1;
        end
        if (upd_fire) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_pop       = (r_state == ST_IDLE) && i_cmd_valid && (is_lookup || out_can);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && is_lookup) begin
                        r_key        <= i_cmd.source_address;
                        r_hit_vec    <= hit_vec;
                        r_free_vec   <= free_vec;
                        r_victim_vec <= victim_vec;
                        r_state      <= ST_UPDATE;
                    end else if (i_cmd_valid && out_can) begin
                        r_out <= rd_out;
                    end
                end
                ST_UPDATE: begin
                    if (out_can) begin
                        r_out.result_kind          <= iplc_pkg::KIND_REPORT;
                        r_out.counted              <= 1'b1;
                        r_out.source_address       <= r_key;
                        r_out.packet_count         <= 32'(new_count);
                        r_out.evicted              <= !hit_any && !free_any;
                        r_out.entry_valid          <= 1'b0;
                        r_state                    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (upd_fire) begin
            r_slot_valid[upd_slot] <= 1'b1;
        end
    end

    // Keys, counts and ranks; ranks of invalid slots are never consulted
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_slot_addr[upd_slot]  <= r_key;
            r_slot_count[upd_slot] <= new_count;
            for (int i = 0; i < N; i++) begin
                if (SLOT_W'(i) == upd_slot) begin
                    r_rank[i] <= '0;
                end else if (r_slot_valid[i] && (!hit_any && free_any || r_rank[i] < old_rank)) begin
                    r_rank[i] <= r_rank[i] + SLOT_W'(1);
                end
            end
        end
    end

endmodule

### rtl/core/ipv4_source_lru_packet_counter.sv
// Top level: per-source IPv4 packet counter with an LRU flow table.
// Throughput: one request (frame byte or readout) per cycle while the queue is not full;
//   a counted frame holds the table engine for a match and then an update, absorbed by a 4-deep queue.
// Results: readout and uncounted frame report pass through the queue and the result register;
//   a counted frame report also passes through the update state after its last byte is accepted.
// Reset (synchronous, active low): parser, queue and valid marks clear.
module ipv4_source_lru_packet_counter #(
    parameter int TABLE_ENTRIES = iplc_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_WIDTH   = iplc_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iplc_stream_if.sink   i_in,
    iplc_stream_if.source o_out
);
    // Front end -> queue
    logic           cmd_push;
    iplc_pkg::t_cmd cmd_in;
    logic           q_full;

    // Queue -> table engine
    logic           q_valid;
    logic           q_pop;
    iplc_pkg::t_cmd q_head;

    // Parser tracks byte position and latches ethertype and source address;
    // it issues a request at each frame end and for each readout.
    iplc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ready (i_in.ready),
        .i_full  (q_full),
        .o_push  (cmd_push),
        .o_cmd   (cmd_in)
    );

    // Decouples the byte stream from table updates
    iplc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Associative match, LRU update and result register
    iplc_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.data),
        .i_out_ready (o_out.ready)
    );

endmodule

### rtl/core/iplc_checker.sv
// Port-level checks on the counter's result stream, bound to the top level.
module iplc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input iplc_pkg::t_out_item i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_readout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == iplc_pkg::KIND_READOUT
        |-> !i_out_data.counted && !i_out_data.evicted
            && (i_out_data.entry_valid
                || (i_out_data.source_address == '0 && i_out_data.packet_count == '0)))
        else $error("readout fields inconsistent");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == iplc_pkg::KIND_REPORT
        |-> !i_out_data.entry_valid
            && (i_out_data.counted
                || (i_out_data.source_address == '0 && i_out_data.packet_count == '0
                    && !i_out_data.evicted)))
        else $error("report fields inconsistent");

endmodule

bind ipv4_source_lru_packet_counter iplc_checker u_iplc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
